/* design/pnh_pkg.sv */
`default_nettype none
package pnh_pkg;

  localparam int BYTE_W   = 8;
  localparam int HASH_W   = 32;
  localparam int IDX_W    = 10;
  localparam int STATUS_W = 2;

  // hash * 33 is (hash << 5) + hash
  localparam int HASH_SHIFT = 5;

  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic KIND_SUMMARY = 1'b0;
  localparam logic KIND_READ    = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TOOLONG = 2'd2;

  typedef struct packed {
    logic                kind;
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    length;
    logic [HASH_W-1:0]   path_hash;
    logic [BYTE_W-1:0]   read_byte;
  } res_t;

endpackage
`default_nettype wire

/* design/pnh_if.sv */
`default_nettype none
interface pnh_in_if;
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic [pnh_pkg::BYTE_W-1:0]  path_byte;
  logic                        last;
  logic [pnh_pkg::HASH_W-1:0]  dir_seed;
  logic [pnh_pkg::IDX_W-1:0]   read_index;

  modport source (output valid, command, path_byte, last, dir_seed, read_index,
                  input ready);
  modport sink   (input valid, command, path_byte, last, dir_seed, read_index,
                  output ready);
endinterface

interface pnh_out_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [pnh_pkg::STATUS_W-1:0]  status;
  logic [pnh_pkg::IDX_W-1:0]     length;
  logic [pnh_pkg::HASH_W-1:0]    path_hash;
  logic [pnh_pkg::BYTE_W-1:0]    read_byte;

  modport source (output valid, kind, status, length, path_hash, read_byte,
                  input ready);
  modport sink   (input valid, kind, status, length, path_hash, read_byte,
                  output ready);
endinterface
`default_nettype wire

/* design/pnh_ram.sv */
`default_nettype none
module pnh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* design/pnh_seq.sv */
`default_nettype none
module pnh_seq #(
  parameter int PATH_BYTES = 1024,
  parameter int NAME_BYTES = 255,
  localparam int AW = $clog2(PATH_BYTES),
  localparam int LW = $clog2(PATH_BYTES + 1),
  localparam int CW = $clog2(NAME_BYTES + 1)
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  pnh_in_if.sink                          feed,
  output logic                            put_we,
  output logic [AW-1:0]                   put_addr,
  output logic [pnh_pkg::BYTE_W-1:0]      put_val,
  output logic [pnh_pkg::HASH_W-1:0]      put_hash,
  output logic [AW-1:0]                   path_raddr,
  input  wire logic [pnh_pkg::BYTE_W-1:0] path_rdata,
  output logic [AW-1:0]                   hash_raddr,
  input  wire logic [pnh_pkg::HASH_W-1:0] hash_rdata,
  output logic                            push_valid,
  output pnh_pkg::res_t                   push_data,
  input  wire logic                       push_space
);

  localparam int CMPW = (LW > pnh_pkg::IDX_W) ? LW : pnh_pkg::IDX_W;

  typedef enum logic [2:0] {
    S_IDLE, S_PROC, S_BACK, S_HWAIT, S_RWAIT, S_FIN, S_EMIT
  } state_t;

  state_t                       state, state_next;
  logic                         cmd_q, cmd_q_next;
  logic [pnh_pkg::BYTE_W-1:0]   byte_q, byte_q_next;
  logic                         last_q, last_q_next;
  logic [pnh_pkg::IDX_W-1:0]    ridx_q, ridx_q_next;
  logic [pnh_pkg::HASH_W-1:0]   seed, seed_next;
  logic [pnh_pkg::HASH_W-1:0]   cur_hash, cur_hash_next;
  logic [LW-1:0]                len, len_next;
  logic [CW-1:0]                comp, comp_next;
  logic                         dot0, dot0_next;
  logic                         dot1, dot1_next;
  logic [pnh_pkg::STATUS_W-1:0] err, err_next;
  logic                         stopped, stopped_next;
  logic                         at_start, at_start_next;
  logic [AW-1:0]                scan, scan_next;
  pnh_pkg::res_t                res, res_next;
  logic [pnh_pkg::STATUS_W-1:0] fin_err;
  logic                         in_range;
  state_t                       after;

  assign feed.ready = (state == S_IDLE);
  assign put_addr   = len[AW-1:0];
  assign put_hash   = (cur_hash << pnh_pkg::HASH_SHIFT) + cur_hash
                      + pnh_pkg::HASH_W'(put_val);
  assign push_data  = res;
  assign after      = last_q ? S_FIN : S_IDLE;
  assign in_range   = CMPW'(ridx_q) < CMPW'(len);
  assign fin_err    = (err == pnh_pkg::ST_OK && len >= LW'(PATH_BYTES))
                      ? pnh_pkg::ST_TOOLONG : err;

  always_comb begin
    state_next    = state;
    cmd_q_next    = cmd_q;
    byte_q_next   = byte_q;
    last_q_next   = last_q;
    ridx_q_next   = ridx_q;
    seed_next     = seed;
    cur_hash_next = cur_hash;
    len_next      = len;
    comp_next     = comp;
    dot0_next     = dot0;
    dot1_next     = dot1;
    err_next      = err;
    stopped_next  = stopped;
    at_start_next = at_start;
    scan_next     = scan;
    res_next      = res;
    put_we        = 1'b0;
    put_val       = pnh_pkg::CH_NUL;
    path_raddr    = '0;
    hash_raddr    = '0;
    push_valid    = 1'b0;

    case (state)
      S_IDLE: begin
        if (feed.valid) begin
          cmd_q_next  = feed.command;
          byte_q_next = feed.path_byte;
          last_q_next = feed.last;
          ridx_q_next = feed.read_index;
          if (feed.command == pnh_pkg::CMD_BYTE && at_start) begin
            seed_next     = feed.dir_seed;
            cur_hash_next = feed.dir_seed;
            len_next      = '0;
            comp_next     = '0;
            err_next      = pnh_pkg::ST_OK;
            stopped_next  = 1'b0;
            at_start_next = 1'b0;
          end
          state_next = S_PROC;
        end
      end

      S_PROC: begin
        if (cmd_q == pnh_pkg::CMD_READ) begin
          path_raddr = AW'(ridx_q);
          state_next = S_RWAIT;
        end else begin
          state_next = after;
          if (!stopped && err == pnh_pkg::ST_OK) begin
            if (byte_q == pnh_pkg::CH_NUL) begin
              stopped_next = 1'b1;
            end else if (byte_q == pnh_pkg::CH_SLASH) begin
              comp_next = '0;
              if (comp != '0) begin
                if (comp == CW'(2) && dot0 && dot1) begin
                  if (len < LW'(3)) begin
                    err_next = pnh_pkg::ST_INVALID;
                  end else if (len == LW'(3)) begin
                    len_next      = '0;
                    cur_hash_next = seed;
                  end else begin
                    scan_next  = AW'(len - LW'(3));
                    path_raddr = AW'(len - LW'(4));
                    state_next = S_BACK;
                  end
                end else if (comp == CW'(1) && dot0) begin
                  len_next = len - LW'(1);
                  if (len == LW'(1)) begin
                    cur_hash_next = seed;
                  end else begin
                    hash_raddr = AW'(len - LW'(2));
                    state_next = S_HWAIT;
                  end
                end else if (len >= LW'(PATH_BYTES)) begin
                  err_next = pnh_pkg::ST_TOOLONG;
                end else begin
                  put_we        = 1'b1;
                  put_val       = pnh_pkg::CH_SLASH;
                  len_next      = len + LW'(1);
                  cur_hash_next = put_hash;
                end
              end
            end else begin
              if (comp >= CW'(NAME_BYTES) || len >= LW'(PATH_BYTES)) begin
                err_next = pnh_pkg::ST_TOOLONG;
              end else begin
                put_we        = 1'b1;
                put_val       = byte_q;
                len_next      = len + LW'(1);
                cur_hash_next = put_hash;
                comp_next     = comp + CW'(1);
                if (comp == '0) begin
                  dot0_next = (byte_q == pnh_pkg::CH_DOT);
                end
                if (comp == CW'(1)) begin
                  dot1_next = (byte_q == pnh_pkg::CH_DOT);
                end
              end
            end
          end
        end
      end

      S_BACK: begin
        // path_rdata holds the byte at scan - 1
        if (path_rdata == pnh_pkg::CH_SLASH) begin
          len_next   = LW'(scan);
          hash_raddr = scan - AW'(1);
          state_next = S_HWAIT;
        end else if (scan == AW'(1)) begin
          len_next      = '0;
          cur_hash_next = seed;
          state_next    = after;
        end else begin
          scan_next  = scan - AW'(1);
          path_raddr = scan - AW'(2);
        end
      end

      S_HWAIT: begin
        cur_hash_next = hash_rdata;
        state_next    = after;
      end

      S_RWAIT: begin
        res_next.kind      = pnh_pkg::KIND_READ;
        res_next.status    = pnh_pkg::ST_OK;
        res_next.length    = '0;
        res_next.path_hash = '0;
        res_next.read_byte = in_range ? path_rdata : pnh_pkg::CH_NUL;
        state_next         = S_EMIT;
      end

      S_FIN: begin
        err_next           = fin_err;
        res_next.kind      = pnh_pkg::KIND_SUMMARY;
        res_next.status    = fin_err;
        res_next.length    = (fin_err == pnh_pkg::ST_OK) ? pnh_pkg::IDX_W'(len) : '0;
        res_next.path_hash = (fin_err == pnh_pkg::ST_OK) ? cur_hash : '0;
        res_next.read_byte = '0;
        at_start_next      = 1'b1;
        state_next         = S_EMIT;
      end

      S_EMIT: begin
        push_valid = 1'b1;
        if (push_space) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cmd_q  <= cmd_q_next;
    byte_q <= byte_q_next;
    last_q <= last_q_next;
    ridx_q <= ridx_q_next;
    scan   <= scan_next;
    res    <= res_next;
    if (rst) begin
      state    <= S_IDLE;
      seed     <= '0;
      cur_hash <= '0;
      len      <= '0;
      comp     <= '0;
      dot0     <= 1'b0;
      dot1     <= 1'b0;
      err      <= pnh_pkg::ST_OK;
      stopped  <= 1'b0;
      at_start <= 1'b1;
    end else begin
      state    <= state_next;
      seed     <= seed_next;
      cur_hash <= cur_hash_next;
      len      <= len_next;
      comp     <= comp_next;
      dot0     <= dot0_next;
      dot1     <= dot1_next;
      err      <= err_next;
      stopped  <= stopped_next;
      at_start <= at_start_next;
    end
  end

endmodule
`default_nettype wire

/* design/pnh_outbuf.sv */
`default_nettype none
module pnh_outbuf (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push_valid,
  input  wire pnh_pkg::res_t  push_data,
  output logic                push_space,
  pnh_out_if.source           result
);

  logic          valid;
  pnh_pkg::res_t data;

  assign push_space = !valid || result.ready;

  always_ff @(posedge clk) begin
    if (push_valid && push_space) begin
      data <= push_data;
    end
    if (rst) begin
      valid <= 1'b0;
    end else if (push_space) begin
      valid <= push_valid;
    end
  end

  assign result.valid     = valid;
  assign result.kind      = data.kind;
  assign result.status    = data.status;
  assign result.length    = data.length;
  assign result.path_hash = data.path_hash;
  assign result.read_byte = data.read_byte;

endmodule
`default_nettype wire

/* design/path_normalize_hash_unit.sv */
`default_nettype none
// Channel | Role   | Word
// feed    | sink   | command, path_byte, last, dir_seed, read_index
// result  | source | kind, status, length, path_hash, read_byte
//
// A path byte is accepted, then stored with its hash update in both memories.
// A '..' component scans stored bytes back to the previous slash, then reloads the
// prefix hash from its memory or takes the seed; a '.' also reloads the prefix hash.
// Read-back: S_RWAIT, S_EMIT; summary: S_FIN, S_EMIT; then the output register.
// Reset is synchronous; the byte and prefix hash memories are not cleared.
// A result waiting in the output register does not block intake of the next word.
module path_normalize_hash_unit #(
  parameter int PATH_BYTES = 1024,
  parameter int NAME_BYTES = 255
) (
  input  wire logic clk,
  input  wire logic rst,
  pnh_in_if.sink    feed,
  pnh_out_if.source result
);

  localparam int AW = $clog2(PATH_BYTES);

  logic                       put_we;
  logic [AW-1:0]              put_addr;
  logic [pnh_pkg::BYTE_W-1:0] put_val;
  logic [pnh_pkg::HASH_W-1:0] put_hash;
  logic [AW-1:0]              path_raddr;
  logic [pnh_pkg::BYTE_W-1:0] path_rdata;
  logic [AW-1:0]              hash_raddr;
  logic [pnh_pkg::HASH_W-1:0] hash_rdata;
  logic                       push_valid;
  pnh_pkg::res_t              push_data;
  logic                       push_space;

  pnh_ram #(.WIDTH(pnh_pkg::BYTE_W), .DEPTH(PATH_BYTES)) u_path_ram (
    .clk   (clk),
    .we    (put_we),
    .waddr (put_addr),
    .wdata (put_val),
    .raddr (path_raddr),
    .rdata (path_rdata)
  );

  pnh_ram #(.WIDTH(pnh_pkg::HASH_W), .DEPTH(PATH_BYTES)) u_hash_ram (
    .clk   (clk),
    .we    (put_we),
    .waddr (put_addr),
    .wdata (put_hash),
    .raddr (hash_raddr),
    .rdata (hash_rdata)
  );

  pnh_seq #(.PATH_BYTES(PATH_BYTES), .NAME_BYTES(NAME_BYTES)) u_seq (
    .clk        (clk),
    .rst        (rst),
    .feed       (feed),
    .put_we     (put_we),
    .put_addr   (put_addr),
    .put_val    (put_val),
    .put_hash   (put_hash),
    .path_raddr (path_raddr),
    .path_rdata (path_rdata),
    .hash_raddr (hash_raddr),
    .hash_rdata (hash_rdata),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_space (push_space)
  );

  pnh_outbuf u_outbuf (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_space (push_space),
    .result     (result)
  );

endmodule
`default_nettype wire

/* design/pnh_chk.sv */
`default_nettype none
module pnh_chk (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         result_valid,
  input wire logic                         result_ready,
  input wire logic                         kind,
  input wire logic [pnh_pkg::STATUS_W-1:0] status,
  input wire logic [pnh_pkg::IDX_W-1:0]    length,
  input wire logic [pnh_pkg::HASH_W-1:0]   path_hash,
  input wire logic [pnh_pkg::BYTE_W-1:0]   read_byte
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(kind) && $stable(status)
      && $stable(length) && $stable(path_hash) && $stable(read_byte))
    else $error("result word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  a_read_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind == pnh_pkg::KIND_READ
      |-> status == pnh_pkg::ST_OK && length == '0 && path_hash == '0)
    else $error("read-back word carries summary fields");

  a_error_summary: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind == pnh_pkg::KIND_SUMMARY && status != pnh_pkg::ST_OK
      |-> length == '0 && path_hash == '0 && read_byte == '0)
    else $error("error summary carries length or hash");

endmodule

bind path_normalize_hash_unit pnh_chk u_chk (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .kind         (result.kind),
  .status       (result.status),
  .length       (result.length),
  .path_hash    (result.path_hash),
  .read_byte    (result.read_byte)
);
`default_nettype wire
